// File: rtl/ccm_pkg.sv
// ----------------------------------------------------------------------------
// ccm_pkg
// Shared types, constants and helpers of the circle-circle manifold unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ccm_pkg;

    localparam int DEF_FRACTION_BITS = 16;
    localparam int CW                = 32;
    localparam int RW                = 30;
    localparam int PW                = 31;
    localparam int NW                = 18;
    localparam int SQ_STEPS          = 32;
    localparam int RAD_W             = 64;
    localparam int REM_W             = 34;

    typedef struct packed {
        logic        hit;
        logic        sx;
        logic        sy;
        logic [30:0] ax;
        logic [30:0] ay;
        logic [30:0] rsum;
        logic [29:0] ra;
    } t_sq_side;

    typedef struct packed {
        logic        hit;
        logic        zero;
        logic        sx;
        logic        sy;
        logic [30:0] pen;
    } t_dv_side;

    function automatic logic [NW-1:0] f_norm_sat(input logic neg, input logic [31:0] mag);
        logic signed [33:0] v;
        v = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
        if (v > 34'sd131071) v = 34'sd131071;
        if (v < -34'sd131072) v = -34'sd131072;
        return v[NW-1:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/ccm_if.sv
// ----------------------------------------------------------------------------
// ccm_in_if / ccm_out_if
// Valid/ready channels carrying circle pair requests and manifold results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ccm_in_if import ccm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] center_a_x;
    logic signed [CW-1:0] center_a_y;
    logic signed [CW-1:0] center_b_x;
    logic signed [CW-1:0] center_b_y;
    logic        [RW-1:0] radius_a;
    logic        [RW-1:0] radius_b;

    modport source (output valid, center_a_x, center_a_y, center_b_x, center_b_y,
                    radius_a, radius_b, input ready);
    modport sink   (input valid, center_a_x, center_a_y, center_b_x, center_b_y,
                    radius_a, radius_b, output ready);
endinterface

interface ccm_out_if import ccm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic        [PW-1:0] penetration;
    logic signed [NW-1:0] normal_x;
    logic signed [NW-1:0] normal_y;

    modport source (output valid, hit, penetration, normal_x, normal_y, input ready);
    modport sink   (input valid, hit, penetration, normal_x, normal_y, output ready);
endinterface

`default_nettype wire

// File: rtl/ccm_front.sv
// ----------------------------------------------------------------------------
// ccm_front
// Offset, magnitude, squares and hit test over four pipeline stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ccm_front import ccm_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire logic signed [CW-1:0] i_ax,
    input  wire logic signed [CW-1:0] i_ay,
    input  wire logic signed [CW-1:0] i_bx,
    input  wire logic signed [CW-1:0] i_by,
    input  wire logic        [RW-1:0] i_ra,
    input  wire logic        [RW-1:0] i_rb,
    output logic                      o_valid,
    output logic         [RAD_W-1:0]  o_rad,
    output t_sq_side                  o_side
);

    logic [3:0] r_v;

    // stage A
    logic signed [32:0] r_nx, r_ny;
    logic        [30:0] r_a_rsum;
    logic        [29:0] r_a_ra;
    // stage B
    logic        [32:0] r_b_ax, r_b_ay;
    logic               r_b_far, r_b_sx, r_b_sy;
    logic        [30:0] r_b_rsum;
    logic        [29:0] r_b_ra;
    // stage C
    logic        [61:0] r_px, r_py, r_prs;
    logic               r_c_far, r_c_sx, r_c_sy;
    logic        [30:0] r_c_ax, r_c_ay, r_c_rsum;
    logic        [29:0] r_c_ra;
    // stage D
    logic        [62:0] r_sq;
    t_sq_side           r_side;

    logic        [32:0] n_ax, n_ay;
    logic        [62:0] n_sq;

    always_comb begin
        n_ax = r_nx[32] ? 33'(-r_nx) : 33'(r_nx);
        n_ay = r_ny[32] ? 33'(-r_ny) : 33'(r_ny);
        n_sq = {1'b0, r_px} + {1'b0, r_py};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nx     <= {i_ax[31], i_ax} - {i_bx[31], i_bx};
            r_ny     <= {i_ay[31], i_ay} - {i_by[31], i_by};
            r_a_rsum <= {1'b0, i_ra} + {1'b0, i_rb};
            r_a_ra   <= i_ra;

            r_b_ax   <= n_ax;
            r_b_ay   <= n_ay;
            r_b_far  <= (n_ax > {2'b00, r_a_rsum}) || (n_ay > {2'b00, r_a_rsum});
            r_b_sx   <= r_nx[32];
            r_b_sy   <= r_ny[32];
            r_b_rsum <= r_a_rsum;
            r_b_ra   <= r_a_ra;

            r_px     <= r_b_ax[30:0] * r_b_ax[30:0];
            r_py     <= r_b_ay[30:0] * r_b_ay[30:0];
            r_prs    <= r_b_rsum * r_b_rsum;
            r_c_far  <= r_b_far;
            r_c_sx   <= r_b_sx;
            r_c_sy   <= r_b_sy;
            r_c_ax   <= r_b_ax[30:0];
            r_c_ay   <= r_b_ay[30:0];
            r_c_rsum <= r_b_rsum;
            r_c_ra   <= r_b_ra;

            r_sq        <= n_sq;
            r_side.hit  <= !r_c_far && (n_sq <= {1'b0, r_prs});
            r_side.sx   <= r_c_sx;
            r_side.sy   <= r_c_sy;
            r_side.ax   <= r_c_ax;
            r_side.ay   <= r_c_ay;
            r_side.rsum <= r_c_rsum;
            r_side.ra   <= r_c_ra;
        end
    end

    assign o_valid = r_v[3];
    assign o_rad   = {1'b0, r_sq};
    assign o_side  = r_side;

endmodule

`default_nettype wire

// File: rtl/ccm_sqrt_cell.sv
// ----------------------------------------------------------------------------
// ccm_sqrt_cell
// One restoring square root step: bring down two radicand bits, try, shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ccm_sqrt_cell import ccm_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic [RAD_W-1:0] i_rad,
    input  wire logic [REM_W-1:0] i_rem,
    input  wire logic [31:0]      i_root,
    input  t_sq_side              i_side,
    output logic                  o_valid,
    output logic      [RAD_W-1:0] o_rad,
    output logic      [REM_W-1:0] o_rem,
    output logic      [31:0]      o_root,
    output t_sq_side              o_side
);

    logic [REM_W+1:0] n_t;
    logic [REM_W+1:0] n_trial;
    logic             n_ge;

    always_comb begin
        n_t     = {i_rem, i_rad[RAD_W-1 -: 2]};
        n_trial = {2'b00, i_root, 2'b01};
        n_ge    = n_t >= n_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rad  <= {i_rad[RAD_W-3:0], 2'b00};
            o_rem  <= n_ge ? REM_W'(n_t - n_trial) : REM_W'(n_t);
            o_root <= {i_root[30:0], n_ge};
            o_side <= i_side;
        end
    end

endmodule

`default_nettype wire

// File: rtl/ccm_div_cell.sv
// ----------------------------------------------------------------------------
// ccm_div_cell
// One restoring division step for both normal components.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ccm_div_cell import ccm_pkg::*; #(
    parameter int QW = DEF_FRACTION_BITS + 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [30:0]   i_d,
    input  wire logic [31:0]   i_rem_x,
    input  wire logic [31:0]   i_rem_y,
    input  wire logic [QW-1:0] i_q_x,
    input  wire logic [QW-1:0] i_q_y,
    input  t_dv_side           i_side,
    output logic               o_valid,
    output logic      [30:0]   o_d,
    output logic      [31:0]   o_rem_x,
    output logic      [31:0]   o_rem_y,
    output logic      [QW-1:0] o_q_x,
    output logic      [QW-1:0] o_q_y,
    output t_dv_side           o_side
);

    logic        n_gx, n_gy;
    logic [31:0] n_rx, n_ry;

    always_comb begin
        n_gx = i_rem_x >= {1'b0, i_d};
        n_gy = i_rem_y >= {1'b0, i_d};
        n_rx = n_gx ? i_rem_x - {1'b0, i_d} : i_rem_x;
        n_ry = n_gy ? i_rem_y - {1'b0, i_d} : i_rem_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_d     <= i_d;
            o_rem_x <= {n_rx[30:0], 1'b0};
            o_rem_y <= {n_ry[30:0], 1'b0};
            o_q_x   <= {i_q_x[QW-2:0], n_gx};
            o_q_y   <= {i_q_y[QW-2:0], n_gy};
            o_side  <= i_side;
        end
    end

endmodule

`default_nettype wire

// File: rtl/circle_circle_manifold_unit.sv
// ----------------------------------------------------------------------------
// circle_circle_manifold_unit
// Collision manifold of two circles: hit, penetration depth and unit normal.
// ----------------------------------------------------------------------------
//  channel | dir | contents
//  i_in    | in  | centers a/b (Q16.16), radii a/b
//  o_out   | out | hit, penetration, normal_x, normal_y
//
//  One request per cycle while o_out is not stalled. The chain: 4 front stages,
//  32 square root cells, FRACTION_BITS + 1 divider cells, output register.
//  Reset clears all valid bits at once; no clearing pass.
//  A stall on o_out freezes the whole chain; i_in.ready follows o_out.ready
//  while the output register is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module circle_circle_manifold_unit import ccm_pkg::*; #(
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ccm_in_if.sink    i_in,
    ccm_out_if.source o_out
);

    localparam int QW = FRACTION_BITS + 1;
    localparam int DS = FRACTION_BITS + 1;

    logic en;
    logic r_o_valid;

    assign en         = !r_o_valid || o_out.ready;
    assign i_in.ready = en;

    logic                   sq_v    [0:SQ_STEPS];
    logic       [RAD_W-1:0] sq_rad  [0:SQ_STEPS];
    logic       [REM_W-1:0] sq_rem  [0:SQ_STEPS];
    logic       [31:0]      sq_root [0:SQ_STEPS];
    t_sq_side               sq_side [0:SQ_STEPS];

    ccm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in.valid),
        .i_ax    (i_in.center_a_x),
        .i_ay    (i_in.center_a_y),
        .i_bx    (i_in.center_b_x),
        .i_by    (i_in.center_b_y),
        .i_ra    (i_in.radius_a),
        .i_rb    (i_in.radius_b),
        .o_valid (sq_v[0]),
        .o_rad   (sq_rad[0]),
        .o_side  (sq_side[0])
    );

    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sq
        ccm_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sq_v[g]),
            .i_rad   (sq_rad[g]),
            .i_rem   (sq_rem[g]),
            .i_root  (sq_root[g]),
            .i_side  (sq_side[g]),
            .o_valid (sq_v[g+1]),
            .o_rad   (sq_rad[g+1]),
            .o_rem   (sq_rem[g+1]),
            .o_root  (sq_root[g+1]),
            .o_side  (sq_side[g+1])
        );
    end

    logic              dv_v    [0:DS];
    logic     [30:0]   dv_d    [0:DS];
    logic     [31:0]   dv_rx   [0:DS];
    logic     [31:0]   dv_ry   [0:DS];
    logic     [QW-1:0] dv_qx   [0:DS];
    logic     [QW-1:0] dv_qy   [0:DS];
    t_dv_side          dv_side [0:DS];

    t_sq_side sq_last;
    logic     [30:0] d_root;

    always_comb begin
        sq_last          = sq_side[SQ_STEPS];
        d_root           = sq_root[SQ_STEPS][30:0];
        dv_v[0]          = sq_v[SQ_STEPS];
        dv_d[0]          = d_root;
        dv_rx[0]         = {1'b0, sq_last.ax};
        dv_ry[0]         = {1'b0, sq_last.ay};
        dv_qx[0]         = '0;
        dv_qy[0]         = '0;
        dv_side[0].hit   = sq_last.hit;
        dv_side[0].zero  = d_root == '0;
        dv_side[0].sx    = sq_last.sx;
        dv_side[0].sy    = sq_last.sy;
        if (!sq_last.hit) begin
            dv_side[0].pen = '0;
        end else if (d_root == '0) begin
            dv_side[0].pen = {1'b0, sq_last.ra};
        end else begin
            dv_side[0].pen = sq_last.rsum - d_root;
        end
    end

    for (genvar g = 0; g < DS; g++) begin : g_dv
        ccm_div_cell #(.QW(QW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (dv_v[g]),
            .i_d     (dv_d[g]),
            .i_rem_x (dv_rx[g]),
            .i_rem_y (dv_ry[g]),
            .i_q_x   (dv_qx[g]),
            .i_q_y   (dv_qy[g]),
            .i_side  (dv_side[g]),
            .o_valid (dv_v[g+1]),
            .o_d     (dv_d[g+1]),
            .o_rem_x (dv_rx[g+1]),
            .o_rem_y (dv_ry[g+1]),
            .o_q_x   (dv_qx[g+1]),
            .o_q_y   (dv_qy[g+1]),
            .o_side  (dv_side[g+1])
        );
    end

    t_dv_side          dl;
    logic              n_hit;
    logic     [PW-1:0] n_pen;
    logic     [NW-1:0] n_nx, n_ny;
    logic              r_hit;
    logic     [PW-1:0] r_pen;
    logic     [NW-1:0] r_nx, r_ny;

    always_comb begin
        dl    = dv_side[DS];
        n_hit = dl.hit;
        n_pen = dl.pen;
        if (!dl.hit) begin
            n_nx = '0;
            n_ny = '0;
        end else if (dl.zero) begin
            n_nx = f_norm_sat(1'b0, 32'(1) << FRACTION_BITS);
            n_ny = '0;
        end else begin
            n_nx = f_norm_sat(dl.sx, 32'(dv_qx[DS]));
            n_ny = f_norm_sat(dl.sy, 32'(dv_qy[DS]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= dv_v[DS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit <= n_hit;
            r_pen <= n_pen;
            r_nx  <= n_nx;
            r_ny  <= n_ny;
        end
    end

    assign o_out.valid       = r_o_valid;
    assign o_out.hit         = r_hit;
    assign o_out.penetration = r_pen;
    assign o_out.normal_x    = r_nx;
    assign o_out.normal_y    = r_ny;

endmodule

`default_nettype wire

// File: rtl/ccm_checker.sv
// ----------------------------------------------------------------------------
// ccm_checker
// Port-level checks of the circle-circle manifold unit, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ccm_checker import ccm_pkg::*; (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_out_valid,
    input wire logic                 i_out_ready,
    input wire logic                 i_hit,
    input wire logic        [PW-1:0] i_pen,
    input wire logic signed [NW-1:0] i_nx,
    input wire logic signed [NW-1:0] i_ny
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_hit |-> i_pen == '0 && i_nx == '0 && i_ny == '0)
        else $error("miss carries nonzero manifold");

    a_hit_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_hit |-> i_nx != '0 || i_ny != '0)
        else $error("hit with zero normal");

    a_reset_empty: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind circle_circle_manifold_unit ccm_checker u_ccm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_hit       (o_out.hit),
    .i_pen       (o_out.penetration),
    .i_nx        (o_out.normal_x),
    .i_ny        (o_out.normal_y)
);

`default_nettype wire
